// ===== hw/rtl/imubma_pkg.sv =====
// Shared types and fixed constants for the IMU bias calibration and moving-average block.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package imubma_pkg;

    localparam int SMP_W    = 16;
    localparam int CH_NUM   = 6;
    localparam int AXIS_NUM = 3;

    // Calibration counter and gyro sum widths.
    localparam int CNT_W = 7;
    localparam int SUM_W = 23;

    // Magnitude width of a gyro calibration sum, the dividend of the bias division.
    localparam int DIV_W = 22;

    // Conversion to deg/s in Q.4: floor(m * 40 / 41) = (m * RATE_MULT) >> RATE_SHIFT
    // for every magnitude m up to 32768.
    localparam int                      RATE_SHIFT  = 27;
    localparam int                      RATE_MULT_W = 27;
    localparam logic [RATE_MULT_W-1:0]  RATE_MULT   = 27'd130944160;

    typedef logic signed [SMP_W-1:0] t_smp;

    typedef struct packed {
        t_smp accel_x_sample;
        t_smp accel_y_sample;
        t_smp accel_z_sample;
        t_smp gyro_x_sample;
        t_smp gyro_y_sample;
        t_smp gyro_z_sample;
    } t_smp_beat;

    typedef struct packed {
        t_smp accel_x_avg;
        t_smp accel_y_avg;
        t_smp accel_z_avg;
        t_smp gyro_x_rate;
        t_smp gyro_y_rate;
        t_smp gyro_z_rate;
        logic bias_ready;
    } t_avg_beat;

    typedef struct packed {
        logic busy;      // bias divider running
        logic bias_now;  // bias valid once the current beat is taken
    } t_cal_status;

endpackage

// ===== hw/rtl/imubma_smp_if.sv =====
// Valid/ready channel that carries one six-axis sample set per beat.
// Depends on imubma_pkg.
`timescale 1ns / 1ps

interface imubma_smp_if;
    logic                  valid;
    logic                  ready;
    imubma_pkg::t_smp_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/imubma_avg_if.sv =====
// Valid/ready channel that carries one set of averaged results per beat.
// Depends on imubma_pkg.
`timescale 1ns / 1ps

interface imubma_avg_if;
    logic                  valid;
    logic                  ready;
    imubma_pkg::t_avg_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/imubma_cal.sv =====
// Gyro bias calibration: sums the first calibration sets, divides by reciprocal multiplication,
// magnitude first and sign after, then subtracts the bias from later gyro readings with saturation.
// Depends on imubma_pkg.
`timescale 1ns / 1ps

module imubma_cal #(
    parameter int CAL_SAMPLES = 100
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  imubma_pkg::t_smp         i_gyro [imubma_pkg::AXIS_NUM],
    output imubma_pkg::t_smp         o_gyro [imubma_pkg::AXIS_NUM],
    output imubma_pkg::t_cal_status  o_status
);

    localparam int CNT_W = imubma_pkg::CNT_W;
    localparam int SUM_W = imubma_pkg::SUM_W;
    localparam int DIV_W = imubma_pkg::DIV_W;
    localparam int SMP_W = imubma_pkg::SMP_W;
    localparam int AXES  = imubma_pkg::AXIS_NUM;

    // Reciprocal of the calibration length, exact for every sum magnitude below 2**DIV_W.
    localparam int             DIV_SHIFT  = DIV_W + $clog2(CAL_SAMPLES);
    localparam int             DIV_PROD_W = DIV_SHIFT + SMP_W;
    localparam logic [DIV_W:0] DIV_RECIP  =
        (DIV_W + 1)'((2 ** DIV_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);

    logic                                 r_bias_valid;
    logic                                 r_busy;
    logic                                 r_step;
    logic [CNT_W-1:0]                     r_cnt;
    logic signed [SUM_W-1:0]              r_sum  [AXES];
    logic [SMP_W-1:0]                     r_quo  [AXES];
    logic                                 r_neg  [AXES];
    imubma_pkg::t_smp                     r_bias [AXES];

    logic [CNT_W-1:0]                     n_cnt;
    logic                                 w_cal_last;
    logic                                 w_cal_take;
    logic signed [SUM_W-1:0]              n_sum  [AXES];
    logic [DIV_W-1:0]                     w_mag  [AXES];
    logic [DIV_PROD_W-1:0]                w_prod [AXES];
    logic signed [SMP_W:0]                w_diff [AXES];

    assign n_cnt      = r_cnt + 1'b1;
    assign w_cal_last = (n_cnt >= CAL_LAST);
    assign w_cal_take = i_accept && !r_bias_valid;

    always_comb begin
        for (int c = 0; c < AXES; c++) begin
            n_sum[c]  = r_sum[c] + SUM_W'(i_gyro[c]);
            // Truncation toward zero: divide the magnitude, restore the sign afterwards.
            w_mag[c]  = r_sum[c][SUM_W-1] ? DIV_W'(-r_sum[c]) : DIV_W'(r_sum[c]);
            w_prod[c] = DIV_PROD_W'(w_mag[c]) * DIV_PROD_W'(DIV_RECIP);

            w_diff[c] = (SMP_W + 1)'(i_gyro[c]) - (SMP_W + 1)'(r_bias[c]);
            if (!r_bias_valid) begin
                o_gyro[c] = i_gyro[c];
            end else if (w_diff[c][SMP_W] != w_diff[c][SMP_W-1]) begin
                o_gyro[c] = w_diff[c][SMP_W] ? {1'b1, {(SMP_W-1){1'b0}}}
                                             : {1'b0, {(SMP_W-1){1'b1}}};
            end else begin
                o_gyro[c] = w_diff[c][SMP_W-1:0];
            end
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.bias_now = r_bias_valid || w_cal_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_cnt        <= '0;
            r_step       <= 1'b0;
            for (int c = 0; c < AXES; c++) begin
                r_sum[c] <= '0;
            end
        end else if (r_busy) begin
            r_step <= 1'b1;
            if (r_step) begin
                r_busy <= 1'b0;
            end
        end else if (w_cal_take) begin
            r_cnt <= n_cnt;
            for (int c = 0; c < AXES; c++) begin
                r_sum[c] <= n_sum[c];
            end
            if (w_cal_last) begin
                r_bias_valid <= 1'b1;
                r_busy       <= 1'b1;
                r_step       <= 1'b0;
            end
        end
    end

    // While busy, the quotient magnitude is registered first and the sign is applied to it after.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            for (int c = 0; c < AXES; c++) begin
                if (!r_step) begin
                    r_quo[c] <= w_prod[c][DIV_SHIFT + SMP_W - 1:DIV_SHIFT];
                    r_neg[c] <= r_sum[c][SUM_W-1];
                end else begin
                    r_bias[c] <= r_neg[c] ? -r_quo[c] : r_quo[c];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/imubma_cell.sv =====
// One cell of the window chain: holds a partial window sum and passes it on,
// adding the newest sample each time the chain shifts. Depends on imubma_pkg.
`timescale 1ns / 1ps

module imubma_cell #(
    parameter int ACC_W = 19
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_shift,
    input  imubma_pkg::t_smp         i_smp,
    input  logic signed [ACC_W-1:0]  i_part,
    output logic signed [ACC_W-1:0]  o_part
);

    logic signed [ACC_W-1:0] r_part;
    logic signed [ACC_W-1:0] n_part;

    assign n_part = i_part + ACC_W'(i_smp);
    assign o_part = r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= '0;
        end else if (i_shift) begin
            r_part <= n_part;
        end
    end

endmodule

// ===== hw/rtl/imubma_avg.sv =====
// Back end: divides each window sum by the window length, converts gyro averages
// to deg/s in Q.4 and holds the result beat. Depends on imubma_pkg, imubma_avg_if.
`timescale 1ns / 1ps

module imubma_avg #(
    parameter int WINDOW = 5,
    parameter int ACC_W  = 19
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [ACC_W-1:0]  i_sum [imubma_pkg::CH_NUM],
    input  logic                     i_flag,
    output logic                     o_take,
    imubma_avg_if.source             o_avg
);

    localparam int SMP_W  = imubma_pkg::SMP_W;
    localparam int CH     = imubma_pkg::CH_NUM;
    localparam int AXES   = imubma_pkg::AXIS_NUM;
    localparam int SHIFT  = ACC_W - 1 + $clog2(WINDOW);
    localparam int PROD_W = ACC_W + SHIFT + 1;
    localparam int RATE_W = SMP_W + imubma_pkg::RATE_MULT_W;
    // Reciprocal of the window length, exact for every magnitude the sum can take.
    localparam logic [SHIFT:0] RECIP = (SHIFT + 1)'((2 ** SHIFT + WINDOW - 1) / WINDOW);

    logic                   w_adv2;
    logic                   w_adv3;
    logic [ACC_W-1:0]       w_mag  [CH];
    logic [PROD_W-1:0]      w_prod [CH];
    logic [RATE_W-1:0]      w_rate [AXES];
    logic [SMP_W-1:0]       w_q2   [AXES];
    imubma_pkg::t_smp       w_res  [CH];

    logic                   r_s2_valid;
    logic                   r_s2_flag;
    logic [SMP_W-1:0]       r_q1  [CH];
    logic                   r_neg [CH];
    logic                   r_o_valid;
    imubma_pkg::t_avg_beat  r_o_data;
    imubma_pkg::t_avg_beat  n_o_data;

    assign w_adv3 = !r_o_valid || o_avg.ready;
    assign w_adv2 = !r_s2_valid || w_adv3;
    assign o_take = w_adv2;

    always_comb begin
        for (int c = 0; c < CH; c++) begin
            w_mag[c]  = i_sum[c][ACC_W-1] ? ACC_W'(-i_sum[c]) : ACC_W'(i_sum[c]);
            w_prod[c] = PROD_W'(w_mag[c]) * PROD_W'(RECIP);
        end
        for (int c = 0; c < AXES; c++) begin
            w_rate[c] = RATE_W'(r_q1[AXES + c]) * RATE_W'(imubma_pkg::RATE_MULT);
            w_q2[c]   = w_rate[c][imubma_pkg::RATE_SHIFT + SMP_W - 1:imubma_pkg::RATE_SHIFT];
        end
        // Truncation toward zero: work on magnitudes, restore the sign at the end.
        for (int c = 0; c < AXES; c++) begin
            w_res[c]        = r_neg[c] ? -r_q1[c] : r_q1[c];
            w_res[AXES + c] = r_neg[AXES + c] ? -w_q2[c] : w_q2[c];
        end
        n_o_data.accel_x_avg = w_res[0];
        n_o_data.accel_y_avg = w_res[1];
        n_o_data.accel_z_avg = w_res[2];
        n_o_data.gyro_x_rate = w_res[3];
        n_o_data.gyro_y_rate = w_res[4];
        n_o_data.gyro_z_rate = w_res[5];
        n_o_data.bias_ready  = r_s2_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_adv2) begin
                r_s2_valid <= i_valid;
            end
            if (w_adv3) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_flag <= i_flag;
            for (int c = 0; c < CH; c++) begin
                r_q1[c]  <= w_prod[c][SHIFT + SMP_W - 1:SHIFT];
                r_neg[c] <= i_sum[c][ACC_W-1];
            end
        end
        if (w_adv3) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_avg.valid = r_o_valid;
    assign o_avg.data  = r_o_data;

endmodule

// ===== hw/rtl/imubma_top.sv =====
// A sample set that is taken passes the window-sum, divide and output registers before it is
// presented as a result beat. Throughput: one sample set per cycle, set by the per-channel
// chain of window cells, while result beats are taken and no bias division runs. After the
// final calibration set the input is held off while the gyro bias is formed by reciprocal
// multiplication and sign restore; results keep draining.
// Reset (synchronous, active low) clears the windows, the calibration state and all beats.
`timescale 1ns / 1ps

module imu_bias_cal_moving_average_top #(
    parameter int WINDOW      = 5,
    parameter int CAL_SAMPLES = 100
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imubma_smp_if.sink    i_smp,
    imubma_avg_if.source  o_avg
);

    localparam int SMP_W = imubma_pkg::SMP_W;
    localparam int CH    = imubma_pkg::CH_NUM;
    localparam int AXES  = imubma_pkg::AXIS_NUM;
    localparam int HIST  = WINDOW - 1;
    localparam int ACC_W = SMP_W + $clog2(WINDOW);

    imubma_pkg::t_cal_status  w_status;
    imubma_pkg::t_smp         w_gyro_raw [AXES];
    imubma_pkg::t_smp         w_gyro_cor [AXES];
    imubma_pkg::t_smp         w_x        [CH];
    logic signed [ACC_W-1:0]  w_part     [CH][HIST];
    logic signed [ACC_W-1:0]  w_y        [CH];
    logic                     w_accept;
    logic                     w_take1;
    logic                     w_take2;

    logic                     r_s1_valid;
    logic                     r_s1_flag;
    logic signed [ACC_W-1:0]  r_s1_y [CH];

    assign w_take1     = !r_s1_valid || w_take2;
    assign i_smp.ready = w_take1 && !w_status.busy;
    assign w_accept    = i_smp.valid && i_smp.ready;

    assign w_gyro_raw[0] = i_smp.data.gyro_x_sample;
    assign w_gyro_raw[1] = i_smp.data.gyro_y_sample;
    assign w_gyro_raw[2] = i_smp.data.gyro_z_sample;

    imubma_cal #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_cal (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_gyro   (w_gyro_raw),
        .o_gyro   (w_gyro_cor),
        .o_status (w_status)
    );

    assign w_x[0] = i_smp.data.accel_x_sample;
    assign w_x[1] = i_smp.data.accel_y_sample;
    assign w_x[2] = i_smp.data.accel_z_sample;
    assign w_x[3] = w_gyro_cor[0];
    assign w_x[4] = w_gyro_cor[1];
    assign w_x[5] = w_gyro_cor[2];

    // Transposed chain: cell k holds the sum of the newest HIST-k values, so the
    // head cell plus the incoming sample is the whole window.
    for (genvar ch = 0; ch < CH; ch++) begin : g_ch
        for (genvar k = 0; k < HIST; k++) begin : g_cell
            logic signed [ACC_W-1:0] w_in;
            if (k == HIST - 1) begin : g_tail
                assign w_in = '0;
            end else begin : g_link
                assign w_in = w_part[ch][k + 1];
            end
            imubma_cell #(
                .ACC_W (ACC_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_smp   (w_x[ch]),
                .i_part  (w_in),
                .o_part  (w_part[ch][k])
            );
        end
        assign w_y[ch] = w_part[ch][0] + ACC_W'(w_x[ch]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_take1) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take1) begin
            r_s1_flag <= w_status.bias_now;
            for (int c = 0; c < CH; c++) begin
                r_s1_y[c] <= w_y[c];
            end
        end
    end

    imubma_avg #(
        .WINDOW (WINDOW),
        .ACC_W  (ACC_W)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_sum   (r_s1_y),
        .i_flag  (r_s1_flag),
        .o_take  (w_take2),
        .o_avg   (o_avg)
    );

endmodule

// ===== tb/sv/imu_bias_cal_moving_average_top_tb.sv =====
// Testbench for the IMU gyro bias calibration and moving-average block: drives sample sets,
// predicts each result beat in place and compares it field by field with the block's output.
// Depends on imubma_pkg, the two channel interfaces and imu_bias_cal_moving_average_top.
`timescale 1ns / 1ps

module imu_bias_cal_moving_average_top_tb;

    localparam int WIN          = 5;
    localparam int CAL_N        = 100;
    localparam int HIST_N       = WIN - 1;
    localparam int CLK_HALF     = 4;
    localparam int RST_CYCLES   = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int SEG_LEN      = 50;
    localparam int SEG_NUM      = 13;

    localparam imubma_pkg::t_smp CORNER [9] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                                16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFE,
                                                16'sh8001};

    logic i_clk;
    logic i_rst_n;

    imubma_smp_if smp_ch ();
    imubma_avg_if avg_ch ();

    imu_bias_cal_moving_average_top #(
        .WINDOW     (WIN),
        .CAL_SAMPLES(CAL_N)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_ch),
        .o_avg  (avg_ch)
    );

    // Predicted state of the block.
    logic [imubma_pkg::CNT_W-1:0]        cal_cnt;
    logic signed [imubma_pkg::SUM_W-1:0] gyro_sum  [imubma_pkg::AXIS_NUM];
    imubma_pkg::t_smp                    gyro_bias [imubma_pkg::AXIS_NUM];
    logic                                bias_ok;
    imubma_pkg::t_smp                    win_hist  [imubma_pkg::CH_NUM][HIST_N];

    imubma_pkg::t_avg_beat avg_expect_q [$];

    int  sets_sent;
    int  beats_checked;
    int  sat_hits;
    int  mismatch_cnt;
    int  quiet_cycles;
    int  rx_hold_req;
    bit  tx_idle_on;
    bit  rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic void clear_predictor();
        cal_cnt = '0;
        bias_ok = 1'b0;
        for (int a = 0; a < imubma_pkg::AXIS_NUM; a++) begin
            gyro_sum[a]  = '0;
            gyro_bias[a] = '0;
        end
        for (int c = 0; c < imubma_pkg::CH_NUM; c++)
            for (int k = 0; k < HIST_N; k++)
                win_hist[c][k] = '0;
    endfunction

    function automatic imubma_pkg::t_avg_beat predict_avg_beat(input imubma_pkg::t_smp_beat s);
        imubma_pkg::t_smp      chan [imubma_pkg::CH_NUM];
        imubma_pkg::t_smp      res  [imubma_pkg::CH_NUM];
        longint                diff;
        int                    acc;
        int                    avg;
        imubma_pkg::t_avg_beat r;
        chan[0] = s.accel_x_sample;
        chan[1] = s.accel_y_sample;
        chan[2] = s.accel_z_sample;
        chan[3] = s.gyro_x_sample;
        chan[4] = s.gyro_y_sample;
        chan[5] = s.gyro_z_sample;
        if (bias_ok) begin
            for (int a = 0; a < imubma_pkg::AXIS_NUM; a++) begin
                diff = longint'(chan[imubma_pkg::AXIS_NUM + a]) - longint'(gyro_bias[a]);
                if (diff > 32767) begin
                    chan[imubma_pkg::AXIS_NUM + a] = 16'sh7FFF;
                    sat_hits++;
                end else if (diff < -32768) begin
                    chan[imubma_pkg::AXIS_NUM + a] = 16'sh8000;
                    sat_hits++;
                end else begin
                    chan[imubma_pkg::AXIS_NUM + a] = imubma_pkg::t_smp'(diff);
                end
            end
        end else begin
            // The final calibration set still passes uncorrected but is part of the bias.
            for (int a = 0; a < imubma_pkg::AXIS_NUM; a++)
                gyro_sum[a] = gyro_sum[a] + chan[imubma_pkg::AXIS_NUM + a];
            cal_cnt = cal_cnt + 1'b1;
            if (cal_cnt >= CAL_N) begin
                for (int a = 0; a < imubma_pkg::AXIS_NUM; a++)
                    gyro_bias[a] = imubma_pkg::t_smp'(int'(gyro_sum[a]) / CAL_N);
                bias_ok = 1'b1;
            end
        end
        for (int c = 0; c < imubma_pkg::CH_NUM; c++) begin
            acc = chan[c];
            for (int k = 0; k < HIST_N; k++)
                acc += win_hist[c][k];
            avg = acc / WIN;
            if (c >= imubma_pkg::AXIS_NUM)
                avg = (avg * 40) / 41;
            res[c] = imubma_pkg::t_smp'(avg);
            for (int k = HIST_N - 1; k > 0; k--)
                win_hist[c][k] = win_hist[c][k - 1];
            win_hist[c][0] = chan[c];
        end
        r.accel_x_avg = res[0];
        r.accel_y_avg = res[1];
        r.accel_z_avg = res[2];
        r.gyro_x_rate = res[3];
        r.gyro_y_rate = res[4];
        r.gyro_z_rate = res[5];
        r.bias_ready  = bias_ok;
        return r;
    endfunction

    function automatic imubma_pkg::t_smp_beat make_set(
        input imubma_pkg::t_smp ax, input imubma_pkg::t_smp ay, input imubma_pkg::t_smp az,
        input imubma_pkg::t_smp gx, input imubma_pkg::t_smp gy, input imubma_pkg::t_smp gz);
        imubma_pkg::t_smp_beat s;
        s.accel_x_sample = ax;
        s.accel_y_sample = ay;
        s.accel_z_sample = az;
        s.gyro_x_sample  = gx;
        s.gyro_y_sample  = gy;
        s.gyro_z_sample  = gz;
        return s;
    endfunction

    function automatic imubma_pkg::t_smp rand_smp();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return imubma_pkg::t_smp'(int'($urandom_range(0, 15)) - 8);
            default: return imubma_pkg::t_smp'($urandom());
        endcase
    endfunction

    function automatic imubma_pkg::t_smp_beat rand_set();
        return make_set(rand_smp(), rand_smp(), rand_smp(), rand_smp(), rand_smp(), rand_smp());
    endfunction

    task automatic send_set(input imubma_pkg::t_smp_beat s);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            smp_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        smp_ch.valid <= 1'b1;
        smp_ch.data  <= s;
        do @(posedge i_clk); while (!(smp_ch.valid && smp_ch.ready));
        avg_expect_q.push_back(predict_avg_beat(s));
        sets_sent++;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        smp_ch.valid <= 1'b0;
    endtask

    task automatic wait_all_results();
        while (avg_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Field extremes while calibration is still summing.
    task automatic test_cal_extremes();
        for (int i = 0; i < 9; i++)
            send_set(make_set(CORNER[i], CORNER[i], CORNER[i], CORNER[i], CORNER[i], CORNER[i]));
        for (int i = 0; i < 9; i++)
            send_set(make_set(CORNER[i], CORNER[(i + 1) % 9], CORNER[(i + 2) % 9],
                              CORNER[(i + 3) % 9], CORNER[(i + 4) % 9], CORNER[(i + 5) % 9]));
    endtask

    // Push gyro X toward a large positive bias and gyro Y toward a large negative one,
    // so that later extremes saturate in both directions.
    task automatic test_cal_complete();
        while (cal_cnt < CAL_N - 1)
            send_set(make_set(rand_smp(), rand_smp(), rand_smp(),
                              imubma_pkg::t_smp'($urandom_range(20000, 32767)),
                              imubma_pkg::t_smp'(-int'($urandom_range(20000, 32768))),
                              rand_smp()));
        send_set(make_set(imubma_pkg::t_smp'(1234), imubma_pkg::t_smp'(-1234), 16'sh0000,
                          16'sh7FFF, 16'sh8000, 16'shFFFF));
    endtask

    task automatic test_gyro_saturation();
        send_set(make_set(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF));
        send_set(make_set(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000));
        send_set(make_set(16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000));
        send_set(make_set(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
        send_set(make_set(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
        send_set(make_set(16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF));
    endtask

    // The receiver stalls for a long stretch while sets keep coming, so the input backs up.
    task automatic test_output_hold();
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = LONG_HOLD;
        repeat (40) send_set(rand_set());
    endtask

    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (10) send_set(rand_set());
        idle_input();
        wait_all_results();
        repeat (10) send_set(rand_set());
    endtask

    task automatic test_random_stream();
        int mode;
        for (int seg = 0; seg < SEG_NUM; seg++) begin
            mode       = $urandom_range(0, 3);
            tx_idle_on = mode[0];
            rx_idle_on = mode[1];
            repeat (SEG_LEN) send_set(rand_set());
        end
    endtask

    task automatic test_full_rate();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (60) send_set(rand_set());
        idle_input();
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        imubma_pkg::t_avg_beat want;
        imubma_pkg::t_avg_beat got;
        if (i_rst_n && avg_ch.valid && avg_ch.ready) begin
            if (avg_expect_q.size() == 0) begin
                $error("result beat arrived with no sample set pending");
                mismatch_cnt++;
            end else begin
                want = avg_expect_q.pop_front();
                got  = avg_ch.data;
                check_field("accel_x_avg", want.accel_x_avg, got.accel_x_avg);
                check_field("accel_y_avg", want.accel_y_avg, got.accel_y_avg);
                check_field("accel_z_avg", want.accel_z_avg, got.accel_z_avg);
                check_field("gyro_x_rate", want.gyro_x_rate, got.gyro_x_rate);
                check_field("gyro_y_rate", want.gyro_y_rate, got.gyro_y_rate);
                check_field("gyro_z_rate", want.gyro_z_rate, got.gyro_z_rate);
                check_field("bias_ready", want.bias_ready, got.bias_ready);
                beats_checked++;
            end
        end
    end

    initial begin : rx_side
        int   burst_left;
        int   hold_left;
        logic rdy;
        burst_left   = 0;
        hold_left    = 0;
        avg_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                rdy = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 13) - 1;
                rdy        = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            avg_ch.ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (avg_ch.valid && avg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no beat moved for %0d cycles", STALL_LIMIT);
            $display("imu_bias_cal_moving_average_top_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.data   = '0;
        sets_sent     = 0;
        beats_checked = 0;
        sat_hits      = 0;
        mismatch_cnt  = 0;
        quiet_cycles  = 0;
        rx_hold_req   = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        clear_predictor();
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cal_extremes();
        test_cal_complete();
        test_gyro_saturation();
        test_output_hold();
        test_drain_pause();
        test_random_stream();
        test_full_rate();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d sample sets and %0d checked result beats, calibration included,",
                 sets_sent, beats_checked);
        $display("with %0d saturated gyro corrections, a long output stall and random idle gaps.",
                 sat_hits);
        if (mismatch_cnt == 0)
            $display("imu_bias_cal_moving_average_top_tb: done, clean");
        else
            $display("imu_bias_cal_moving_average_top_tb: done, errors");
        $finish;
    end

endmodule
